/* rtl/assert_macros.svh */
// assertion macros used by counter_priority_task_picker
// no dependencies; define ASSERT_OFF to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/cptp_pkg.sv */
// shared types and constants of the task picker
// slot entry layout, run state codes and signal masks; no dependencies
package cptp_pkg;

	localparam logic [2:0] RS_RUNNING       = 3'd0;
	localparam logic [2:0] RS_INTERRUPTIBLE = 3'd1;

	localparam logic [31:0] ALARM_BIT   = 32'h0000_2000;
	localparam logic [31:0] UNBLOCKABLE = 32'h0004_0100;
	localparam logic [6:0]  WEIGHT_RESET = 7'd15;

	typedef struct packed {
		logic        used;
		logic [2:0]  run_state;
		logic [7:0]  slice;
		logic [6:0]  weight;
		logic [31:0] pending;
		logic [31:0] blocked;
		logic [31:0] alarm;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	localparam entry_t ENTRY_RESET = '{
		used: 1'b0,
		run_state: RS_RUNNING,
		slice: 8'd0,
		weight: WEIGHT_RESET,
		pending: 32'd0,
		blocked: 32'd0,
		alarm: 32'd0
	};

	typedef struct packed {
		logic        refill;
		logic [31:0] now;
	} sweep_ctl_t;

endpackage

/* rtl/cptp_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
module cptp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/cptp_slot_alu.sv */
// per-slot update: alarm expiry and wake in the first sweep, refill in the second
// depends on cptp_pkg
module cptp_slot_alu (
	input  cptp_pkg::entry_t     cur,
	input  cptp_pkg::sweep_ctl_t ctl,
	output cptp_pkg::entry_t     nxt,
	output logic                 wr,
	output logic                 runnable
);
	import cptp_pkg::*;

	logic        fire;
	logic [31:0] pend;
	logic        wake;
	logic [8:0]  sum;

	always_comb begin
		fire = cur.used && (cur.alarm != 32'd0) && (cur.alarm < ctl.now);
		pend = cur.pending | (fire ? ALARM_BIT : 32'd0);
		wake = cur.used && (cur.run_state == RS_INTERRUPTIBLE)
			&& ((pend & ~(cur.blocked & ~UNBLOCKABLE)) != 32'd0);
		sum = {2'b00, cur.slice[7:1]} + {2'b00, cur.weight};
		nxt = cur;
		if (ctl.refill) begin
			nxt.slice = sum[8] ? 8'hFF : sum[7:0];
		end else begin
			nxt.pending = pend;
			if (fire) begin
				nxt.alarm = 32'd0;
			end
			if (wake) begin
				nxt.run_state = RS_RUNNING;
			end
		end
		wr = cur.used;
		runnable = cur.used && (nxt.run_state == RS_RUNNING);
	end

endmodule

/* rtl/counter_priority_task_picker.sv */
// counter priority task picker: top level with sweep sequencer and result register
// depends on cptp_pkg, cptp_ram, cptp_slot_alu and assert_macros.svh
//
// usage:
// input channel in_valid/in_ready carries one item per handshake. mode 0 writes
// every field of one slot in the accept cycle; slots at or above TASK_SLOTS are
// ignored and no result follows. mode 1 starts a scheduling pass with now_tick.
// a pass sweeps slots 1..TASK_SLOTS-1 through the slot ram, one read per cycle,
// waking tasks and tracking the best counter; if that counter is zero a second
// sweep refills counters and searches again. a final ram read fetches the
// chosen slot's counter.
// in_ready is high only between passes, and write items may follow back to back.
// the result waits in an output register: a low out_ready does not stop writes or
// the start of the next pass, but that pass holds in finish, in_ready low, until loaded.
// reset clears the sequencer, the result valid flag and the per-slot valid bits;
// slots never written read as their reset values, so no clearing pass is needed.
module counter_priority_task_picker #(
	parameter int TASK_SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [5:0]  slot,
	input  logic        present,
	input  logic [2:0]  run_state,
	input  logic [7:0]  time_slice,
	input  logic [6:0]  weight,
	input  logic [31:0] pending_signals,
	input  logic [31:0] blocked_signals,
	input  logic [31:0] alarm_tick,
	input  logic [31:0] now_tick,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  chosen_task,
	output logic [7:0]  chosen_slice,
	output logic        refilled
);
	import cptp_pkg::*;
	`include "assert_macros.svh"

	localparam int AW = $clog2(TASK_SLOTS);
	localparam logic [AW-1:0] LAST_IDX = AW'(TASK_SLOTS - 1);
	localparam logic [AW-1:0] FIRST_IDX = AW'(1);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SWEEP  = 5'b00010,
		ST_DRAIN  = 5'b00100,
		ST_PICK   = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t state_q, state_d;

	logic [AW-1:0]         rd_idx_q;
	logic                  refill_q;
	logic [31:0]           now_q;
	logic                  best_vld_q;
	logic [7:0]            best_c_q;
	logic [AW-1:0]         best_idx_q;
	logic [TASK_SLOTS-1:0] valid_q;

	logic                  act_s1;
	logic [AW-1:0]         addr_s1;
	logic                  rd_vld_s1;

	logic                  out_valid_q;
	logic [5:0]            chosen_task_q;
	logic [7:0]            chosen_slice_q;
	logic                  refilled_q;

	logic                  in_acc;
	logic                  wr_item;
	logic                  pass_item;
	logic [AW-1:0]         pick;
	logic [AW-1:0]         rd_addr;
	logic [ENTRY_W-1:0]    ram_rdata;
	entry_t                ent_rd;
	entry_t                ent_in;
	entry_t                alu_nxt;
	logic                  alu_wr;
	logic                  alu_run;
	sweep_ctl_t            sweep_ctl;
	logic                  wb_en;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	entry_t                ram_wdata;
	logic                  cand;
	logic                  best_vld_n;
	logic [7:0]            best_c_n;
	logic [AW-1:0]         best_idx_n;
	logic                  go_refill;
	logic                  load_out;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign wr_item   = in_acc && !mode && (32'(slot) < 32'(TASK_SLOTS));
	assign pass_item = in_acc && mode;

	assign pick = best_vld_q ? best_idx_q : '0;

	always_comb begin
		case (state_q)
			ST_PICK, ST_FINISH: rd_addr = pick;
			default:            rd_addr = rd_idx_q;
		endcase
	end

	assign ent_rd = rd_vld_s1 ? entry_t'(ram_rdata) : ENTRY_RESET;

	assign ent_in = '{
		used: present,
		run_state: run_state,
		slice: time_slice,
		weight: weight,
		pending: pending_signals,
		blocked: blocked_signals,
		alarm: alarm_tick
	};

	assign sweep_ctl = '{refill: refill_q, now: now_q};

	cptp_slot_alu u_alu (
		.cur      (ent_rd),
		.ctl      (sweep_ctl),
		.nxt      (alu_nxt),
		.wr       (alu_wr),
		.runnable (alu_run)
	);

	assign wb_en     = act_s1 && alu_wr;
	assign ram_we    = wr_item || wb_en;
	assign ram_waddr = wr_item ? AW'(slot) : addr_s1;
	assign ram_wdata = wr_item ? ent_in : alu_nxt;

	cptp_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TASK_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// running search, higher slot wins ties since slots arrive in ascending order
	always_comb begin
		cand = act_s1 && alu_run && (!best_vld_q || (alu_nxt.slice >= best_c_q));
		best_vld_n = best_vld_q || cand;
		best_c_n   = cand ? alu_nxt.slice : best_c_q;
		best_idx_n = cand ? addr_s1 : best_idx_q;
		go_refill  = !refill_q && best_vld_n && (best_c_n == 8'd0);
		load_out   = (state_q == ST_FINISH) && (!out_valid_q || out_ready);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (pass_item) state_d = ST_SWEEP;
			end
			ST_SWEEP: begin
				if (rd_idx_q == LAST_IDX) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = go_refill ? ST_SWEEP : ST_PICK;
			end
			ST_PICK: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (load_out) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_idx_q    <= FIRST_IDX;
			refill_q    <= 1'b0;
			best_vld_q  <= 1'b0;
			act_s1      <= 1'b0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			act_s1  <= (state_q == ST_SWEEP);
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (pass_item) begin
				rd_idx_q   <= FIRST_IDX;
				refill_q   <= 1'b0;
				best_vld_q <= 1'b0;
			end else if (state_q == ST_SWEEP) begin
				rd_idx_q   <= rd_idx_q + AW'(1);
				best_vld_q <= best_vld_n;
			end else if (state_q == ST_DRAIN) begin
				rd_idx_q   <= FIRST_IDX;
				if (go_refill) begin
					refill_q   <= 1'b1;
					best_vld_q <= 1'b0;
				end else begin
					best_vld_q <= best_vld_n;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1   <= rd_addr;
		rd_vld_s1 <= valid_q[rd_addr];
		if (pass_item) begin
			now_q <= now_tick;
		end
		if (state_q == ST_SWEEP || state_q == ST_DRAIN) begin
			best_c_q   <= best_c_n;
			best_idx_q <= best_idx_n;
		end
		if (load_out) begin
			chosen_task_q  <= 6'(pick);
			chosen_slice_q <= ent_rd.slice;
			refilled_q     <= refill_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign chosen_task  = chosen_task_q;
	assign chosen_slice = chosen_slice_q;
	assign refilled     = refilled_q;

	// sweep write-back never lands on the entry being read
	`ASSERT_IMPLIES(a_no_rw_clash, clk, arst_n,
		(state_q == ST_SWEEP) && wb_en, ram_waddr != rd_addr)
	// at most one refill sweep per pass
	`ASSERT_NEXT(a_one_refill, clk, arst_n,
		(state_q == ST_DRAIN) && refill_q, state_q == ST_PICK)
	// a new result only appears out of the finish state
	`ASSERT_IMPLIES(a_load_src, clk, arst_n,
		$rose(out_valid_q), $past(state_q == ST_FINISH))

endmodule

/* tb/tb.sv */
// testbench for counter_priority_task_picker: slot writes and scheduling passes
// checked against an in-bench task table predictor; depends on cptp_pkg and the rtl
`timescale 1ns / 1ps

module tb;
	import cptp_pkg::*;

	localparam int TASK_SLOTS = 64;
	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 2 * TASK_SLOTS + 20;
	localparam int RANDOM_ITEMS = 1800;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_SCHED = 1'b1;

	localparam logic [2:0] RS_UNINTERRUPTIBLE = 3'd2;
	localparam logic [2:0] RS_ZOMBIE          = 3'd3;
	localparam logic [2:0] RS_STOPPED         = 3'd4;
	localparam logic [2:0] RS_UNDEF_LOW       = 3'd5;
	localparam logic [2:0] RS_UNDEF_HIGH      = 3'd7;

	typedef struct {
		logic        mode;
		logic [5:0]  slot;
		logic        present;
		logic [2:0]  run_state;
		logic [7:0]  time_slice;
		logic [6:0]  weight;
		logic [31:0] pending;
		logic [31:0] blocked;
		logic [31:0] alarm;
		logic [31:0] now;
	} sched_item_t;

	typedef struct {
		logic [5:0] chosen;
		logic [7:0] slice;
		logic       refilled;
	} pick_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        mode;
	logic [5:0]  slot;
	logic        present;
	logic [2:0]  run_state;
	logic [7:0]  time_slice;
	logic [6:0]  weight;
	logic [31:0] pending_signals;
	logic [31:0] blocked_signals;
	logic [31:0] alarm_tick;
	logic [31:0] now_tick;
	logic        out_valid;
	logic        out_ready;
	logic [5:0]  chosen_task;
	logic [7:0]  chosen_slice;
	logic        refilled;

	// task table as the predictor sees it
	logic        tbl_used   [TASK_SLOTS];
	logic [2:0]  tbl_state  [TASK_SLOTS];
	logic [7:0]  tbl_count  [TASK_SLOTS];
	logic [6:0]  tbl_weight [TASK_SLOTS];
	logic [31:0] tbl_pend   [TASK_SLOTS];
	logic [31:0] tbl_block  [TASK_SLOTS];
	logic [31:0] tbl_alarm  [TASK_SLOTS];

	pick_t expected_picks[$];
	int    mismatch_count;
	int    items_sent;
	int    burst_left;
	int    ready_left;
	logic  ready_level;
	int    idle_cycles;
	logic [31:0] tick_now;
	logic [5:0]  slot_pool [6];

	counter_priority_task_picker #(
		.TASK_SLOTS(TASK_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.slot(slot),
		.present(present),
		.run_state(run_state),
		.time_slice(time_slice),
		.weight(weight),
		.pending_signals(pending_signals),
		.blocked_signals(blocked_signals),
		.alarm_tick(alarm_tick),
		.now_tick(now_tick),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.chosen_task(chosen_task),
		.chosen_slice(chosen_slice),
		.refilled(refilled)
	);

	always #6 clk = ~clk;

	function automatic void clear_table();
		for (int i = 0; i < TASK_SLOTS; i++) begin
			tbl_used[i] = 1'b0;
			tbl_state[i] = RS_RUNNING;
			tbl_count[i] = 8'd0;
			tbl_weight[i] = WEIGHT_RESET;
			tbl_pend[i] = 32'd0;
			tbl_block[i] = 32'd0;
			tbl_alarm[i] = 32'd0;
		end
	endfunction

	function automatic void store_slot(sched_item_t it);
		if (int'(it.slot) < TASK_SLOTS) begin
			tbl_used[it.slot] = it.present;
			tbl_state[it.slot] = it.run_state;
			tbl_count[it.slot] = it.time_slice;
			tbl_weight[it.slot] = it.weight;
			tbl_pend[it.slot] = it.pending;
			tbl_block[it.slot] = it.blocked;
			tbl_alarm[it.slot] = it.alarm;
		end
	endfunction

	// highest counter among running tasks, higher slot on ties; -1 if none
	function automatic int best_running(output logic [5:0] pick);
		int c;
		c = -1;
		pick = '0;
		for (int i = TASK_SLOTS - 1; i >= 1; i--) begin
			if (tbl_used[i] && tbl_state[i] == RS_RUNNING && int'(tbl_count[i]) > c) begin
				c = int'(tbl_count[i]);
				pick = 6'(i);
			end
		end
		return c;
	endfunction

	function automatic pick_t schedule_pass(logic [31:0] now);
		pick_t r;
		logic [8:0] v;
		int c;
		for (int i = 1; i < TASK_SLOTS; i++) begin
			if (tbl_used[i]) begin
				if (tbl_alarm[i] != 32'd0 && tbl_alarm[i] < now) begin
					tbl_pend[i] = tbl_pend[i] | ALARM_BIT;
					tbl_alarm[i] = 32'd0;
				end
				if ((tbl_pend[i] & ~(tbl_block[i] & ~UNBLOCKABLE)) != 32'd0 &&
					tbl_state[i] == RS_INTERRUPTIBLE)
					tbl_state[i] = RS_RUNNING;
			end
		end
		r.refilled = 1'b0;
		c = best_running(r.chosen);
		if (c == 0) begin
			for (int i = 1; i < TASK_SLOTS; i++) begin
				if (tbl_used[i]) begin
					v = 9'(tbl_count[i] >> 1) + 9'(tbl_weight[i]);
					tbl_count[i] = (v > 9'd255) ? 8'hFF : v[7:0];
				end
			end
			r.refilled = 1'b1;
			c = best_running(r.chosen);
		end
		r.slice = tbl_count[r.chosen];
		return r;
	endfunction

	task automatic send_item(sched_item_t it);
		int gap;
		int r;
		@(negedge clk);
		mode <= it.mode;
		slot <= it.slot;
		present <= it.present;
		run_state <= it.run_state;
		time_slice <= it.time_slice;
		weight <= it.weight;
		pending_signals <= it.pending;
		blocked_signals <= it.blocked;
		alarm_tick <= it.alarm;
		now_tick <= it.now;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		if (it.mode == MODE_WRITE)
			store_slot(it);
		else
			expected_picks.push_back(schedule_pass(it.now));
		items_sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			r = $urandom_range(0, 9);
			if (r < 3)
				gap = 0;
			else if (r < 8)
				gap = $urandom_range(1, 12);
			else
				gap = $urandom_range(20, 150);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
	endtask

	function automatic sched_item_t noise_item();
		sched_item_t it;
		it.mode = MODE_WRITE;
		it.slot = 6'($urandom);
		it.present = 1'($urandom);
		it.run_state = 3'($urandom);
		it.time_slice = 8'($urandom);
		it.weight = 7'($urandom);
		it.pending = $urandom;
		it.blocked = $urandom;
		it.alarm = $urandom;
		it.now = $urandom;
		return it;
	endfunction

	task automatic write_task(logic [5:0] s, logic p, logic [2:0] rs, logic [7:0] cnt,
			logic [6:0] w, logic [31:0] pend, logic [31:0] blk, logic [31:0] alm);
		sched_item_t it;
		it = noise_item();
		it.mode = MODE_WRITE;
		it.slot = s;
		it.present = p;
		it.run_state = rs;
		it.time_slice = cnt;
		it.weight = w;
		it.pending = pend;
		it.blocked = blk;
		it.alarm = alm;
		send_item(it);
	endtask

	task automatic run_pass(logic [31:0] now);
		sched_item_t it;
		it = noise_item();
		it.mode = MODE_SCHED;
		it.now = now;
		send_item(it);
	endtask

	task automatic test_empty_table();
		run_pass(32'd0);
		run_pass(32'hFFFF_FFFF);
	endtask

	task automatic test_slot_zero_fallback();
		write_task(6'd0, 1'b1, RS_RUNNING, 8'hFF, 7'h7F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
		run_pass(32'hFFFF_FFFF);
	endtask

	task automatic test_pick_order();
		write_task(6'd63, 1'b1, RS_RUNNING, 8'hFF, 7'h7F, 32'd0, 32'd0, 32'd0);
		write_task(6'd5, 1'b1, RS_RUNNING, 8'd200, 7'd1, 32'd0, 32'd0, 32'd0);
		write_task(6'd9, 1'b1, RS_RUNNING, 8'd200, 7'd1, 32'd0, 32'd0, 32'd0);
		run_pass(32'd10);
		write_task(6'd63, 1'b1, RS_RUNNING, 8'd100, 7'h7F, 32'd0, 32'd0, 32'd0);
		run_pass(32'd10);
	endtask

	task automatic test_refill();
		write_task(6'd63, 1'b0, RS_RUNNING, 8'd0, 7'h7F, 32'd0, 32'd0, 32'd0);
		write_task(6'd5, 1'b1, RS_RUNNING, 8'd0, 7'd1, 32'd0, 32'd0, 32'd0);
		write_task(6'd9, 1'b1, RS_RUNNING, 8'd0, 7'h7F, 32'd0, 32'd0, 32'd0);
		run_pass(32'd20);
		// zero weight leaves counters at zero after the refill
		write_task(6'd5, 1'b1, RS_RUNNING, 8'd0, 7'd0, 32'd0, 32'd0, 32'd0);
		write_task(6'd9, 1'b1, RS_RUNNING, 8'd0, 7'd0, 32'd0, 32'd0, 32'd0);
		run_pass(32'd20);
	endtask

	task automatic test_wakeup();
		write_task(6'd5, 1'b0, RS_RUNNING, 8'd0, 7'd1, 32'd0, 32'd0, 32'd0);
		write_task(6'd9, 1'b0, RS_RUNNING, 8'd0, 7'd1, 32'd0, 32'd0, 32'd0);
		write_task(6'd20, 1'b1, RS_INTERRUPTIBLE, 8'd50, 7'd3, 32'd0, 32'd0, 32'd1000);
		run_pass(32'd1000);
		run_pass(32'd1001);
		write_task(6'd21, 1'b1, RS_INTERRUPTIBLE, 8'd60, 7'd3, ALARM_BIT, 32'hFFFF_FFFF, 32'd0);
		write_task(6'd22, 1'b1, RS_INTERRUPTIBLE, 8'd70, 7'd3, UNBLOCKABLE, 32'hFFFF_FFFF,
			32'd0);
		write_task(6'd23, 1'b1, RS_UNINTERRUPTIBLE, 8'd80, 7'd3, 32'hFFFF_FFFF, 32'd0, 32'd1);
		write_task(6'd24, 1'b1, RS_UNDEF_HIGH, 8'd90, 7'd3, 32'hFFFF_FFFF, 32'd0, 32'd0);
		write_task(6'd25, 1'b0, RS_RUNNING, 8'hFF, 7'd3, 32'd0, 32'd0, 32'd0);
		write_task(6'd26, 1'b1, RS_ZOMBIE, 8'hFE, 7'd3, 32'hFFFF_FFFF, 32'd0, 32'd0);
		write_task(6'd27, 1'b1, RS_STOPPED, 8'hFD, 7'd3, 32'hFFFF_FFFF, 32'd0, 32'd0);
		run_pass(32'hFFFF_FFFF);
	endtask

	function automatic logic [5:0] pick_slot();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return slot_pool[$urandom_range(0, 5)];
		else if (r == 6)
			return 6'd0;
		else
			return 6'($urandom);
	endfunction

	function automatic sched_item_t random_write(logic [5:0] s);
		sched_item_t it;
		int r;
		it = noise_item();
		it.slot = s;
		it.present = ($urandom_range(0, 9) < 8);
		r = $urandom_range(0, 19);
		if (r < 9)
			it.run_state = RS_RUNNING;
		else if (r < 16)
			it.run_state = RS_INTERRUPTIBLE;
		else if (r < 18)
			it.run_state = 3'($urandom_range(RS_UNINTERRUPTIBLE, RS_STOPPED));
		else
			it.run_state = 3'($urandom_range(RS_UNDEF_LOW, RS_UNDEF_HIGH));
		if ($urandom_range(0, 9) < 4)
			it.time_slice = 8'd0;
		if ($urandom_range(0, 9) == 0)
			it.weight = 7'd0;
		r = $urandom_range(0, 9);
		if (r < 4)
			it.pending = 32'd0;
		else if (r < 7)
			it.pending = 32'd1 << $urandom_range(0, 31);
		r = $urandom_range(0, 9);
		if (r < 3)
			it.blocked = 32'd0;
		else if (r < 6)
			it.blocked = 32'hFFFF_FFFF;
		r = $urandom_range(0, 19);
		if (r < 6)
			it.alarm = 32'd0;
		else if (r < 14)
			it.alarm = tick_now + $urandom_range(0, 300) - 32'd100;
		else if (r < 17)
			it.alarm = (r == 14) ? 32'd1 : 32'hFFFF_FFFF;
		return it;
	endfunction

	task automatic test_random_traffic(int n_items);
		int stop_at;
		int n;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			for (int i = 0; i < 6; i++)
				slot_pool[i] = 6'($urandom_range(1, TASK_SLOTS - 1));
			// retire slots 1 to TASK_SLOTS-1 now and then so refills stay reachable
			if ($urandom_range(0, 15) == 0) begin
				for (int s = 1; s < TASK_SLOTS; s++) begin
					sched_item_t it;
					it = noise_item();
					it.slot = 6'(s);
					it.present = 1'b0;
					send_item(it);
				end
			end
			n = $urandom_range(1, 8);
			repeat (n) send_item(random_write(pick_slot()));
			n = $urandom_range(1, 3);
			repeat (n) begin
				if ($urandom_range(0, 19) == 0)
					tick_now = $urandom;
				else
					tick_now = tick_now + $urandom_range(0, 100);
				run_pass(tick_now);
			end
		end
	endtask

	task automatic report_mismatch(string field, int unsigned exp_v, int unsigned act_v);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch on %s: expected %0d, got %0d", field, exp_v, act_v);
	endtask

	always @(posedge clk) begin : check_results
		pick_t exp_pick;
		if (arst_n && out_valid && out_ready) begin
			if (expected_picks.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("result with no pass pending: task %0d slice %0d refilled %0d",
						chosen_task, chosen_slice, refilled);
			end else begin
				exp_pick = expected_picks.pop_front();
				if (chosen_task !== exp_pick.chosen)
					report_mismatch("chosen_task", exp_pick.chosen, chosen_task);
				if (chosen_slice !== exp_pick.slice)
					report_mismatch("chosen_slice", exp_pick.slice, chosen_slice);
				if (refilled !== exp_pick.refilled)
					report_mismatch("refilled", exp_pick.refilled, refilled);
			end
		end
	end

	always @(negedge clk) begin
		int r;
		if (ready_left == 0) begin
			r = $urandom_range(0, 9);
			if (r < 5) begin
				ready_level = 1'b1;
				ready_left = $urandom_range(1, 60);
			end else if (r < 9) begin
				ready_level = 1'b0;
				ready_left = $urandom_range(1, 10);
			end else begin
				ready_level = 1'b0;
				ready_left = $urandom_range(40, 250);
			end
		end
		out_ready <= ready_level;
		ready_left--;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("counter_priority_task_picker verification failed");
				$finish;
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		mode = MODE_WRITE;
		slot = '0;
		present = 1'b0;
		run_state = RS_RUNNING;
		time_slice = '0;
		weight = '0;
		pending_signals = '0;
		blocked_signals = '0;
		alarm_tick = '0;
		now_tick = '0;
		mismatch_count = 0;
		items_sent = 0;
		burst_left = 1;
		ready_left = 0;
		ready_level = 1'b1;
		idle_cycles = 0;
		tick_now = 32'd500;
		clear_table();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		test_empty_table();
		test_slot_zero_fallback();
		test_pick_order();
		test_refill();
		test_wakeup();
		test_random_traffic(RANDOM_ITEMS);

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_picks.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_picks.size() == 0)
			$display("counter_priority_task_picker verification clean");
		else
			$display("counter_priority_task_picker verification failed");
		$finish;
	end

endmodule
